// ===== hdl/zibsu_pkg.sv =====
// ----------------------------------------------------------------------------
// zibsu_pkg: shared types and constants for the indexed bit/shift unit
// Holds the decoded-instruction and result records, operation codes and the
// flag bit positions used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package zibsu_pkg;

  // Flag bit positions in the flag register.
  localparam int unsigned FL_S = 7;
  localparam int unsigned FL_Z = 6;
  localparam int unsigned FL_H = 4;
  localparam int unsigned FL_P = 2;
  localparam int unsigned FL_N = 1;
  localparam int unsigned FL_C = 0;

  localparam logic [7:0] OPC_SLL      = 8'h36;
  localparam logic [2:0] OPC_LOW_MEM  = 3'd6;
  localparam logic [4:0] CYC_BIT      = 5'd20;
  localparam logic [4:0] CYC_RMW      = 5'd23;
  localparam logic [4:0] CYC_TRAP     = 5'd0;
  localparam logic [7:0] BIT7_MASK    = 8'd128;

  // Operation class decided by the front end.
  typedef enum logic [2:0] {
    OPK_TRAP,
    OPK_SHIFT,
    OPK_BIT,
    OPK_RES,
    OPK_SET
  } op_kind_t;

  // Rotate and shift selection (opcode bits 5-3 in group 0).
  typedef enum logic [2:0] {
    SH_RLC = 3'd0,
    SH_RRC = 3'd1,
    SH_RL  = 3'd2,
    SH_RR  = 3'd3,
    SH_SLA = 3'd4,
    SH_SRA = 3'd5,
    SH_SLL = 3'd6,
    SH_SRL = 3'd7
  } shift_op_t;

  // Instruction group (opcode bits 7-6).
  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } op_group_t;

  typedef struct packed {
    logic [15:0] addr;
    op_kind_t    kind;
    logic [2:0]  sel;
    logic [7:0]  mem_byte;
    logic [7:0]  flags;
  } dec_item_t;

  typedef struct packed {
    logic [15:0] mem_addr;
    logic [7:0]  write_data;
    logic        write_enable;
    logic [7:0]  flags_out;
    logic [4:0]  cycles;
    logic        trap;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/zibsu_in_if.sv =====
// ----------------------------------------------------------------------------
// zibsu_in_if: instruction channel
// Valid/ready channel carrying one indexed bit instruction per transfer.
// ----------------------------------------------------------------------------
interface zibsu_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        opcode;
  logic signed [7:0] disp;
  logic [15:0]       index_reg;
  logic [7:0]        mem_byte;
  logic [7:0]        flags_in;

  modport source (output valid, opcode, disp, index_reg, mem_byte, flags_in,
                  input ready);
  modport sink   (input valid, opcode, disp, index_reg, mem_byte, flags_in,
                  output ready);
endinterface

// ===== hdl/zibsu_out_if.sv =====
// ----------------------------------------------------------------------------
// zibsu_out_if: result channel
// Valid/ready channel carrying one execution result per transfer.
// ----------------------------------------------------------------------------
interface zibsu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mem_addr;
  logic [7:0]  write_data;
  logic        write_enable;
  logic [7:0]  flags_out;
  logic [4:0]  cycles;
  logic        trap;

  modport source (output valid, mem_addr, write_data, write_enable, flags_out,
                  cycles, trap, input ready);
  modport sink   (input valid, mem_addr, write_data, write_enable, flags_out,
                  cycles, trap, output ready);
endinterface

// ===== hdl/zibsu_front.sv =====
// ----------------------------------------------------------------------------
// zibsu_front: instruction accept and classify
// Computes the operand address and sorts the opcode into an operation class,
// marking undefined or disabled opcodes as traps.
// ----------------------------------------------------------------------------
module zibsu_front (
  input  logic                 sll_enabled,
  input  logic [7:0]           opcode,
  input  logic signed [7:0]    disp,
  input  logic [15:0]          index_reg,
  input  logic [7:0]           mem_byte,
  input  logic [7:0]           flags_in,
  output zibsu_pkg::dec_item_t item
);

  logic                 is_trap;
  zibsu_pkg::op_group_t grp;

  assign grp     = zibsu_pkg::op_group_t'(opcode[7:6]);
  assign is_trap = (opcode[2:0] != zibsu_pkg::OPC_LOW_MEM) ||
                   ((opcode == zibsu_pkg::OPC_SLL) && !sll_enabled);

  always_comb begin
    item.addr     = index_reg + {{8{disp[7]}}, disp};
    item.sel      = opcode[5:3];
    item.mem_byte = mem_byte;
    item.flags    = flags_in;
    if (is_trap) begin
      item.kind = zibsu_pkg::OPK_TRAP;
    end else begin
      unique case (grp)
        zibsu_pkg::GRP_SHIFT: item.kind = zibsu_pkg::OPK_SHIFT;
        zibsu_pkg::GRP_BIT:   item.kind = zibsu_pkg::OPK_BIT;
        zibsu_pkg::GRP_RES:   item.kind = zibsu_pkg::OPK_RES;
        default:              item.kind = zibsu_pkg::OPK_SET;
      endcase
    end
  end

endmodule

// ===== hdl/zibsu_queue.sv =====
// ----------------------------------------------------------------------------
// zibsu_queue: two-entry queue between front and back end
// Holds decoded instructions so that either side can stall on its own.
// ----------------------------------------------------------------------------
module zibsu_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  zibsu_pkg::dec_item_t  push_item,
  input  logic                  pop,
  output zibsu_pkg::dec_item_t  head_item,
  output zibsu_pkg::q_status_t  status
);

  zibsu_pkg::dec_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign head_item    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/zibsu_back.sv =====
// ----------------------------------------------------------------------------
// zibsu_back: execution and result register
// Performs the rotate, shift, bit test, reset or set on the operand byte,
// forms the new flags and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module zibsu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  zibsu_pkg::dec_item_t item,
  input  logic                 item_valid,
  output logic                 item_pop,
  output zibsu_pkg::result_t   res,
  output logic                 res_valid,
  input  logic                 res_ready
);

  zibsu_pkg::result_t res_r, res_nxt;
  logic               valid_r, valid_nxt;
  logic               load;
  logic [7:0]         m;
  logic [7:0]         f;
  logic [7:0]         mask;
  logic [7:0]         r;
  logic               cout;
  logic               cin;

  assign m        = item.mem_byte;
  assign f        = item.flags;
  assign cin      = f[zibsu_pkg::FL_C];
  assign mask     = 8'd1 << item.sel;
  assign load     = item_valid && (!valid_r || res_ready);
  assign item_pop = load;

  // Rotate and shift datapath.
  always_comb begin
    case (zibsu_pkg::shift_op_t'(item.sel))
      zibsu_pkg::SH_RLC: begin cout = m[7]; r = {m[6:0], m[7]}; end
      zibsu_pkg::SH_RRC: begin cout = m[0]; r = {m[0], m[7:1]}; end
      zibsu_pkg::SH_RL:  begin cout = m[7]; r = {m[6:0], cin};  end
      zibsu_pkg::SH_RR:  begin cout = m[0]; r = {cin, m[7:1]};  end
      zibsu_pkg::SH_SLA: begin cout = m[7]; r = {m[6:0], 1'b0}; end
      zibsu_pkg::SH_SRA: begin cout = m[0]; r = {m[7], m[7:1]}; end
      zibsu_pkg::SH_SLL: begin cout = m[7]; r = {m[6:0], 1'b1}; end
      default:           begin cout = m[0]; r = {1'b0, m[7:1]}; end
    endcase
  end

  always_comb begin
    res_nxt.mem_addr     = item.addr;
    res_nxt.write_data   = 8'd0;
    res_nxt.write_enable = 1'b0;
    res_nxt.flags_out    = f;
    res_nxt.cycles       = zibsu_pkg::CYC_TRAP;
    res_nxt.trap         = 1'b0;
    unique case (item.kind)
      zibsu_pkg::OPK_SHIFT: begin
        res_nxt.write_data             = r;
        res_nxt.write_enable           = 1'b1;
        res_nxt.cycles                 = zibsu_pkg::CYC_RMW;
        res_nxt.flags_out[zibsu_pkg::FL_S] = r[7];
        res_nxt.flags_out[zibsu_pkg::FL_Z] = (r == 8'd0);
        res_nxt.flags_out[zibsu_pkg::FL_H] = 1'b0;
        res_nxt.flags_out[zibsu_pkg::FL_P] = ~^r;
        res_nxt.flags_out[zibsu_pkg::FL_N] = 1'b0;
        res_nxt.flags_out[zibsu_pkg::FL_C] = cout;
      end
      zibsu_pkg::OPK_BIT: begin
        res_nxt.cycles                     = zibsu_pkg::CYC_BIT;
        res_nxt.flags_out[zibsu_pkg::FL_H] = 1'b1;
        res_nxt.flags_out[zibsu_pkg::FL_N] = 1'b0;
        res_nxt.flags_out[zibsu_pkg::FL_Z] = ((m & mask) == 8'd0);
        res_nxt.flags_out[zibsu_pkg::FL_P] = ((m & mask) == 8'd0);
        // Only a test of bit 7 that finds it set raises the sign flag.
        res_nxt.flags_out[zibsu_pkg::FL_S] = ((m & mask & zibsu_pkg::BIT7_MASK) != 8'd0);
      end
      zibsu_pkg::OPK_RES: begin
        res_nxt.write_data   = m & ~mask;
        res_nxt.write_enable = 1'b1;
        res_nxt.cycles       = zibsu_pkg::CYC_RMW;
      end
      zibsu_pkg::OPK_SET: begin
        res_nxt.write_data   = m | mask;
        res_nxt.write_enable = 1'b1;
        res_nxt.cycles       = zibsu_pkg::CYC_RMW;
      end
      default: begin
        res_nxt.trap = 1'b1;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res       = res_r;
  assign res_valid = valid_r;

endmodule

// ===== hdl/z80_indexed_bit_shift_unit_top.sv =====
// ----------------------------------------------------------------------------
// z80_indexed_bit_shift_unit_top: indexed bit, rotate and shift executor
// Runs one four-byte IY-indexed bit instruction per transfer and returns the
// operand address, write-back byte, new flags, cycle count and trap mark.
// ----------------------------------------------------------------------------
// Usage:
// The instruction channel (in_ch) takes the fourth opcode byte, the signed
// displacement, the index register, the operand byte already read from
// memory and the incoming flags. The result channel (out_ch) returns one
// result per instruction, in order. Both use valid/ready; a transfer happens
// on a rising edge where both are high.
// The front end classifies the opcode and computes the address in the
// accepting cycle and writes the decoded instruction into a two-entry queue.
// The back end executes the queue head and loads the output register, so a
// result passes through the queue entry and then the output register, and one
// instruction per cycle is sustained when nothing stalls; the output register
// and the queue set that rate, there is no loop in the datapath.
// When the receiver holds ready low, the output register keeps its result
// and the queue absorbs up to two more instructions before in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and sets sll_enabled to 1. The APB port holds that one register at byte
// address 0; it is to be written only while the unit is idle.
// ----------------------------------------------------------------------------
module z80_indexed_bit_shift_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  zibsu_in_if.sink    in_ch,
  zibsu_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 sll_enabled_r, sll_enabled_nxt;
  logic                 cfg_write;
  logic                 push;
  logic                 pop;
  zibsu_pkg::dec_item_t front_item;
  zibsu_pkg::dec_item_t head_item;
  zibsu_pkg::q_status_t q_status;
  zibsu_pkg::result_t   res;

  // Configuration: one 1-bit register in word 0; other words read as zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign sll_enabled_nxt = cfg_write ? pwdata[0] : sll_enabled_r;
  assign prdata    = (paddr[2] == 1'b0) ? {31'd0, sll_enabled_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sll_enabled_r <= 1'b1;
    end else begin
      sll_enabled_r <= sll_enabled_nxt;
    end
  end

  // Front end: accept whenever the queue has room.
  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && in_ch.ready;

  zibsu_front u_front (
    .sll_enabled (sll_enabled_r),
    .opcode      (in_ch.opcode),
    .disp        (in_ch.disp),
    .index_reg   (in_ch.index_reg),
    .mem_byte    (in_ch.mem_byte),
    .flags_in    (in_ch.flags_in),
    .item        (front_item)
  );

  zibsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // Back end: executes the queue head into the output register.
  zibsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (head_item),
    .item_valid (!q_status.empty),
    .item_pop   (pop),
    .res        (res),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready)
  );

  assign out_ch.mem_addr     = res.mem_addr;
  assign out_ch.write_data   = res.write_data;
  assign out_ch.write_enable = res.write_enable;
  assign out_ch.flags_out    = res.flags_out;
  assign out_ch.cycles       = res.cycles;
  assign out_ch.trap         = res.trap;

`ifndef SYNTHESIS
  // A trapped instruction never writes memory and reports no cycles.
  a_trap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.trap |-> !out_ch.write_enable &&
    (out_ch.cycles == zibsu_pkg::CYC_TRAP))
    else $error("trap result carries a write or a cycle count");

  // Every executed instruction without write-back is a bit test.
  a_bit_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.trap && !out_ch.write_enable |->
    (out_ch.cycles == zibsu_pkg::CYC_BIT))
    else $error("non-writing result is not a bit test");

  // An instruction entering an empty queue with a free output register
  // shows up on the result channel after the queue entry and the output register.
  a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
    push && q_status.empty && (!out_ch.valid || out_ch.ready) |=> ##1
    out_ch.valid && (out_ch.mem_addr == $past(front_item.addr, 2)))
    else $error("result missing after transfer into an idle unit");

  // The queue is never popped while it is empty.
  a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");
`endif

endmodule

// ===== tb/sv/z80_indexed_bit_shift_unit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// z80_indexed_bit_shift_unit_top_tb: self-checking bench for the indexed unit
// Drives IY-indexed CB-group instructions through the valid/ready channels,
// predicts every result from its own model of rotates, shifts, BIT, RES, SET
// and traps, and compares each returned result field by field. The SLL
// enable register is toggled between phases over the APB port.
// ----------------------------------------------------------------------------
module z80_indexed_bit_shift_unit_top_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [2:0]  SLL_EN_ADDR = 3'd0;

  // Keeps the outstanding predicted results and the mismatch count.
  class indexed_op_scoreboard;
    zibsu_pkg::result_t pending_results[$];
    logic        sll_on;
    int unsigned errors;
    int unsigned n_results;
    int unsigned n_traps;
    int unsigned n_bit_tests;

    function new();
      sll_on      = 1'b1;
      errors      = 0;
      n_results   = 0;
      n_traps     = 0;
      n_bit_tests = 0;
    endfunction

    function void set_sll(logic on);
      sll_on = on;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Computes the result of one instruction from the current SLL setting.
    function zibsu_pkg::result_t execute_indexed_op(logic [7:0] opcode,
                                                    logic [7:0] disp,
                                                    logic [15:0] index,
                                                    logic [7:0] mem,
                                                    logic [7:0] flags);
      zibsu_pkg::result_t res;
      logic [2:0] sel;
      logic [7:0] r;
      logic       cout;
      logic       zero_bit;
      res          = '0;
      sel          = opcode[5:3];
      res.mem_addr = index + {{8{disp[7]}}, disp};
      res.flags_out = flags;
      if (opcode[2:0] != zibsu_pkg::OPC_LOW_MEM ||
          (opcode == zibsu_pkg::OPC_SLL && !sll_on)) begin
        res.trap   = 1'b1;
        res.cycles = zibsu_pkg::CYC_TRAP;
      end else begin
        case (zibsu_pkg::op_group_t'(opcode[7:6]))
          zibsu_pkg::GRP_SHIFT: begin
            case (zibsu_pkg::shift_op_t'(sel))
              zibsu_pkg::SH_RLC: begin cout = mem[7]; r = {mem[6:0], mem[7]}; end
              zibsu_pkg::SH_RRC: begin cout = mem[0]; r = {mem[0], mem[7:1]}; end
              zibsu_pkg::SH_RL: begin
                cout = mem[7];
                r    = {mem[6:0], flags[zibsu_pkg::FL_C]};
              end
              zibsu_pkg::SH_RR: begin
                cout = mem[0];
                r    = {flags[zibsu_pkg::FL_C], mem[7:1]};
              end
              zibsu_pkg::SH_SLA: begin cout = mem[7]; r = {mem[6:0], 1'b0}; end
              zibsu_pkg::SH_SRA: begin cout = mem[0]; r = {mem[7], mem[7:1]}; end
              zibsu_pkg::SH_SLL: begin cout = mem[7]; r = {mem[6:0], 1'b1}; end
              default: begin cout = mem[0]; r = {1'b0, mem[7:1]}; end
            endcase
            res.flags_out[zibsu_pkg::FL_S] = r[7];
            res.flags_out[zibsu_pkg::FL_Z] = (r == 8'd0);
            res.flags_out[zibsu_pkg::FL_H] = 1'b0;
            res.flags_out[zibsu_pkg::FL_P] = ~^r;
            res.flags_out[zibsu_pkg::FL_N] = 1'b0;
            res.flags_out[zibsu_pkg::FL_C] = cout;
            res.write_data      = r;
            res.write_enable    = 1'b1;
            res.cycles          = zibsu_pkg::CYC_RMW;
          end
          zibsu_pkg::GRP_BIT: begin
            zero_bit = ~mem[sel];
            res.flags_out[zibsu_pkg::FL_N] = 1'b0;
            res.flags_out[zibsu_pkg::FL_H] = 1'b1;
            res.flags_out[zibsu_pkg::FL_Z] = zero_bit;
            res.flags_out[zibsu_pkg::FL_P] = zero_bit;
            res.flags_out[zibsu_pkg::FL_S] = (sel == 3'd7) && mem[7];
            res.cycles          = zibsu_pkg::CYC_BIT;
          end
          zibsu_pkg::GRP_RES: begin
            res.write_data   = mem & ~(8'd1 << sel);
            res.write_enable = 1'b1;
            res.cycles       = zibsu_pkg::CYC_RMW;
          end
          default: begin
            res.write_data   = mem | (8'd1 << sel);
            res.write_enable = 1'b1;
            res.cycles       = zibsu_pkg::CYC_RMW;
          end
        endcase
      end
      return res;
    endfunction

    function void note_instr(logic [7:0] opcode, logic [7:0] disp,
                             logic [15:0] index, logic [7:0] mem, logic [7:0] flags);
      pending_results.push_back(execute_indexed_op(opcode, disp, index, mem, flags));
    endfunction

    task check_result(zibsu_pkg::result_t got);
      zibsu_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no instruction outstanding, addr %h", got.mem_addr));
        return;
      end
      want = pending_results.pop_front();
      n_results++;
      if (want.trap) n_traps++;
      if (want.cycles == zibsu_pkg::CYC_BIT) n_bit_tests++;
      if (got.mem_addr !== want.mem_addr)
        report($sformatf("mem_addr got %h want %h", got.mem_addr, want.mem_addr));
      if (got.write_data !== want.write_data)
        report($sformatf("write_data got %h want %h (addr %h)",
                         got.write_data, want.write_data, want.mem_addr));
      if (got.write_enable !== want.write_enable)
        report($sformatf("write_enable got %b want %b (addr %h)",
                         got.write_enable, want.write_enable, want.mem_addr));
      if (got.flags_out !== want.flags_out)
        report($sformatf("flags_out got %h want %h (addr %h)",
                         got.flags_out, want.flags_out, want.mem_addr));
      if (got.cycles !== want.cycles)
        report($sformatf("cycles got %0d want %0d (addr %h)",
                         got.cycles, want.cycles, want.mem_addr));
      if (got.trap !== want.trap)
        report($sformatf("trap got %b want %b (addr %h)", got.trap, want.trap, want.mem_addr));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // When low, neither the instruction sender nor the result receiver idles.
  logic        idle_on;
  int unsigned n_cfg_writes;

  indexed_op_scoreboard sb;

  zibsu_in_if  in_ch ();
  zibsu_out_if out_ch ();

  z80_indexed_bit_shift_unit_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog. The slowest legal run is far below this limit.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("FAILURE");
    $finish;
  end

  // Builds an executable opcode: group in bits 7-6, selector in 5-3, (IY+d) in 2-0.
  function automatic logic [7:0] indexed_opcode(zibsu_pkg::op_group_t grp,
                                                logic [2:0] sel);
    return {grp, sel, zibsu_pkg::OPC_LOW_MEM};
  endfunction

  // Offers one instruction and holds it until the transfer happens. The
  // sender may first go idle for a short burst. Valid is left high so the
  // next call can follow back to back.
  task automatic send_instr(input logic [7:0] opcode, input logic [7:0] disp,
                            input logic [15:0] index, input logic [7:0] mem,
                            input logic [7:0] flags);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= opcode;
    in_ch.disp      <= disp;
    in_ch.index_reg <= index;
    in_ch.mem_byte  <= mem;
    in_ch.flags_in  <= flags;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_instr(opcode, disp, index, mem, flags);
  endtask

  // Stops offering instructions and waits until every predicted result has
  // come back, then lets the two-stage pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. The bus then
  // returns to idle so that a next access never reassigns psel in the same step.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads the SLL enable back and compares it with the predicted setting.
  task automatic check_sll_reg();
    logic [31:0] rd;
    apb_read(SLL_EN_ADDR, rd);
    if (rd !== {31'd0, sb.sll_on})
      sb.report($sformatf("sll_enabled read %h want %h", rd, {31'd0, sb.sll_on}));
  endtask

  // Writes the SLL enable; only called while the unit is idle.
  task automatic set_sll_enable(input logic on);
    apb_write(SLL_EN_ADDR, {31'd0, on});
    sb.set_sll(on);
    n_cfg_writes++;
    check_sll_reg();
  endtask

  // One random instruction. Most are executable opcodes so that the
  // datapath is exercised; the SLL opcode is favored since its handling
  // depends on the register, and a share of fully random bytes covers traps.
  task automatic send_random_instr();
    int unsigned pick;
    logic [7:0]  opcode;
    logic [15:0] index;
    logic [7:0]  mem;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      opcode = 8'($urandom);
    else if (pick < 20)
      opcode = zibsu_pkg::OPC_SLL;
    else
      opcode = indexed_opcode(zibsu_pkg::op_group_t'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)));
    case ($urandom_range(0, 9))
      0: index = 16'h0000;
      1: index = 16'hFFFF;
      default: index = 16'($urandom);
    endcase
    case ($urandom_range(0, 11))
      0: mem = 8'h00;
      1: mem = 8'hFF;
      2: mem = 8'h80;
      3: mem = 8'h01;
      default: mem = 8'($urandom);
    endcase
    send_instr(opcode, 8'($urandom), index, mem, 8'($urandom));
  endtask

  // Result receiver: checks each transfer and stalls in random bursts.
  initial begin
    int unsigned stall_left;
    zibsu_pkg::result_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.mem_addr     = out_ch.mem_addr;
        got.write_data   = out_ch.write_data;
        got.write_enable = out_ch.write_enable;
        got.flags_out    = out_ch.flags_out;
        got.cycles       = out_ch.cycles;
        got.trap         = out_ch.trap;
        sb.check_result(got);
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed cases, then random phases with the SLL
  // enable switched between them. The last phase runs without idling.
  initial begin
    int unsigned phase;
    int unsigned num_phases;
    int unsigned i;
    sb           = new();
    idle_on      = 1'b1;
    n_cfg_writes = 0;
    num_phases   = 5;

    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= '0;
    in_ch.disp      <= '0;
    in_ch.index_reg <= '0;
    in_ch.mem_byte  <= '0;
    in_ch.flags_in  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The register must come out of reset with SLL enabled.
    check_sll_reg();

    // Every rotate and shift, all but SLL on a byte that moves a bit into carry or
    // produces a zero result. The address extremes ride along: the most
    // negative displacement from 0000 and the largest from FFFF both wrap.
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_RLC),
               8'h80, 16'h0000, 8'h80, 8'h00);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_RRC),
               8'h7F, 16'hFFFF, 8'h01, 8'hFF);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_RL),
               8'h00, 16'h1234, 8'h00, 8'hFE);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_RR),
               8'hFF, 16'h8000, 8'h01, 8'h01);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_SLA),
               8'h01, 16'h7FFF, 8'h80, 8'hFF);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_SRA),
               8'h10, 16'h00FF, 8'h81, 8'h00);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_SLL),
               8'hF0, 16'hABCD, 8'h7F, 8'h28);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_SRL),
               8'h05, 16'h5555, 8'h01, 8'hD7);

    // BIT with the tested bit set and clear, including bit 7 which drives S.
    // None of them writes memory.
    send_instr(indexed_opcode(zibsu_pkg::GRP_BIT, 3'd0), 8'h00, 16'h4000, 8'h01, 8'hFF);
    send_instr(indexed_opcode(zibsu_pkg::GRP_BIT, 3'd0), 8'h00, 16'h4000, 8'hFE, 8'h00);
    send_instr(indexed_opcode(zibsu_pkg::GRP_BIT, 3'd7), 8'h00, 16'h4000, 8'h80, 8'h00);
    send_instr(indexed_opcode(zibsu_pkg::GRP_BIT, 3'd7), 8'h00, 16'h4000, 8'h7F, 8'hFF);
    send_instr(indexed_opcode(zibsu_pkg::GRP_BIT, 3'd3), 8'h80, 16'h0001, 8'hFF, 8'h55);

    // RES and SET at both ends of the byte; flags must pass through.
    send_instr(indexed_opcode(zibsu_pkg::GRP_RES, 3'd0), 8'h01, 16'h2000, 8'hFF, 8'hAA);
    send_instr(indexed_opcode(zibsu_pkg::GRP_RES, 3'd7), 8'hFE, 16'h2000, 8'h80, 8'h55);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SET, 3'd0), 8'h01, 16'h2000, 8'h00, 8'hFF);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SET, 3'd7), 8'hFE, 16'h2000, 8'h7F, 8'h00);

    // Undefined opcodes (register operands rather than (IY+d)) trap but
    // still report the operand address.
    send_instr({zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_RLC, 3'd0},
               8'h80, 16'h0000, 8'hFF, 8'hFF);
    send_instr({zibsu_pkg::GRP_SET, 3'd7, 3'd7}, 8'h7F, 16'hFFFF, 8'h00, 8'h00);
    send_instr({zibsu_pkg::GRP_BIT, 3'd1, 3'd5}, 8'h33, 16'hC000, 8'h5A, 8'h93);
    drain();

    // With SLL disabled the same opcode must trap like an undefined one,
    // while its neighbors still execute.
    set_sll_enable(1'b0);
    send_instr(zibsu_pkg::OPC_SLL, 8'h80, 16'h0000, 8'h7F, 8'hFF);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_SRA),
               8'h00, 16'h0100, 8'hFF, 8'h00);
    send_instr(indexed_opcode(zibsu_pkg::GRP_SHIFT, zibsu_pkg::SH_SRL),
               8'h00, 16'h0100, 8'hFF, 8'h00);
    drain();

    // Random phases, alternating the register between its two values.
    for (phase = 0; phase < num_phases; phase++) begin
      set_sll_enable((phase % 2) == 1);
      if (phase == num_phases - 1) idle_on = 1'b0;
      for (i = 0; i < 200; i++) send_random_instr();
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Ran %0d instructions (%0d traps, %0d BIT tests) with %0d SLL enable writes.",
             sb.n_results, sb.n_traps, sb.n_bit_tests, n_cfg_writes);
    $display("Back-pressure and source gaps were applied on all but the final phase.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
